FILE: sv/assert_macros.svh
// Assertion helpers; assume clk and arst_n are visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ADS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ADS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ADS_ASSERT(lbl, prop, msg)
`define ADS_NEVER(lbl, expr, msg)
`endif
`endif

FILE: sv/ads_pkg.sv
package ads_pkg;

	localparam int DL_W        = 32;
	localparam int PER_W       = 16;
	localparam int OUT_ID_W    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] EV_ADDED  = 2'd0;
	localparam logic [1:0] EV_FIRED  = 2'd1;
	localparam logic [1:0] EV_REJECT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIRE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic clr;
		logic smp;
	} scan_ctrl_t;

endpackage

FILE: sv/ads_ram.sv
module ads_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/ads_scan.sv
module ads_scan import ads_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int ID_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  scan_ctrl_t                            ctrl,
	input  logic [DL_W-1:0]                       now,
	input  logic [DL_W+PER_W+1+ID_WIDTH-1:0]      ent,
	input  logic [$clog2(CAPACITY)-1:0]           idx,
	output logic                                  found,
	output logic [DL_W+PER_W+1+ID_WIDTH-1:0]      best_ent,
	output logic [$clog2(CAPACITY)-1:0]           best_idx
);

	localparam int EntW = DL_W + PER_W + 1 + ID_WIDTH;
	localparam int IdxW = $clog2(CAPACITY);

	logic            found_q;
	logic [DL_W-1:0] age_q;
	logic [EntW-1:0] ent_q;
	logic [IdxW-1:0] idx_q;
	logic [DL_W-1:0] age;
	logic            due;
	logic            better;
	logic            take;

	// age wraps; an entry is due while the wrapped age stays in the lower half
	assign age    = now - ent[EntW-1 -: DL_W];
	assign due    = !age[DL_W-1];
	assign better = !found_q || (age > age_q) ||
		((age == age_q) && (ent[ID_WIDTH-1:0] < ent_q[ID_WIDTH-1:0]));
	assign take   = ctrl.smp && due && better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			age_q <= age;
			ent_q <= ent;
			idx_q <= idx;
		end
	end

	assign found    = found_q;
	assign best_ent = ent_q;
	assign best_idx = idx_q;

endmodule

FILE: sv/alarm_deadline_scheduler.sv
// Add, clear: served in idle; the add result beat appears the cycle after start, busy stays low.
// Tick: one scan round (ST_SCAN per slot, ST_DRAIN, ST_FIRE) per fired alarm plus a closing
// round (ST_FLUSH instead when MAX_RESULTS fire); each round reads the entry RAM once a slot.
// Fired beats leave one per round, each strobed for one cycle; the receiver cannot stall.
// Reset clears time, id counter, slot valid bits and the sequencer; RAM contents stay undefined.
`include "assert_macros.svh"

module alarm_deadline_scheduler import ads_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int ID_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          req_type,
	input  logic [15:0]         delay_ticks,
	input  logic                is_periodic,
	output logic                busy,
	output logic                strobe,
	output logic [1:0]          event_kind,
	output logic [OUT_ID_W-1:0] alarm_id,
	output logic                last
);

	localparam int EntW    = DL_W + PER_W + 1 + ID_WIDTH;
	localparam int IdxW    = $clog2(CAPACITY);
	localparam int IdExtW  = (ID_WIDTH > OUT_ID_W) ? ID_WIDTH : OUT_ID_W;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

	state_t                state_q, state_n;
	logic [IdxW-1:0]       idx_q, idx_n;
	logic                  rd_vld_s1;
	logic [IdxW-1:0]       rd_idx_s1;
	logic [CNT_W-1:0]      fire_cnt_q, fire_cnt_n, fire_cnt_inc;
	logic                  pend_q, pend_n;
	logic [ID_WIDTH-1:0]   pend_id_q, pend_id_n;
	logic [DL_W-1:0]       now_q, now_n;
	logic [ID_WIDTH-1:0]   next_id_q, next_id_n;
	logic [CAPACITY-1:0]   valid_q, valid_n;

	logic                  out_stb_q, out_stb_n;
	logic [1:0]            out_kind_q, out_kind_n;
	logic [OUT_ID_W-1:0]   out_id_q, out_id_n;
	logic                  out_last_q, out_last_n;
	logic [IdExtW-1:0]     id_ext;

	logic                  accept;
	logic                  full;
	logic [IdxW-1:0]       free_idx;

	logic                  ram_we, ram_re;
	logic [IdxW-1:0]       ram_waddr;
	logic [EntW-1:0]       ram_wdata, ram_rdata;

	scan_ctrl_t            scan_ctrl;
	logic                  best_found;
	logic [EntW-1:0]       best_ent;
	logic [IdxW-1:0]       best_idx;
	logic [PER_W-1:0]      best_per;
	logic                  best_periodic;
	logic [ID_WIDTH-1:0]   best_id;
	logic [DL_W-1:0]       rearm_step;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = &valid_q;

	assign best_id       = best_ent[ID_WIDTH-1:0];
	assign best_periodic = best_ent[ID_WIDTH];
	assign best_per      = best_ent[ID_WIDTH+1 +: PER_W];
	// a zero period rearms for the next tick
	assign rearm_step    = (best_per == '0) ? DL_W'(1) : DL_W'(best_per);
	assign fire_cnt_inc  = fire_cnt_q + CNT_W'(1);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
			end
		end
	end

	assign ram_re = (state_q == ST_SCAN);

	ads_ram #(
		.WIDTH(EntW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	ads_scan #(
		.CAPACITY(CAPACITY),
		.ID_WIDTH(ID_WIDTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (scan_ctrl),
		.now     (now_q),
		.ent     (ram_rdata),
		.idx     (rd_idx_s1),
		.found   (best_found),
		.best_ent(best_ent),
		.best_idx(best_idx)
	);

	always_comb begin
		state_n       = state_q;
		idx_n         = idx_q;
		fire_cnt_n    = fire_cnt_q;
		pend_n        = pend_q;
		pend_id_n     = pend_id_q;
		now_n         = now_q;
		next_id_n     = next_id_q;
		valid_n       = valid_q;
		ram_we        = 1'b0;
		ram_waddr     = '0;
		ram_wdata     = '0;
		scan_ctrl.clr = 1'b0;
		scan_ctrl.smp = rd_vld_s1 && valid_q[rd_idx_s1];
		out_stb_n     = 1'b0;
		out_kind_n    = EV_FIRED;
		out_last_n    = 1'b0;
		id_ext        = IdExtW'(pend_id_q);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_ADD: begin
							out_stb_n  = 1'b1;
							out_last_n = 1'b1;
							if (full) begin
								out_kind_n = EV_REJECT;
								id_ext     = '0;
							end else begin
								out_kind_n          = EV_ADDED;
								id_ext              = IdExtW'(next_id_q);
								ram_we              = 1'b1;
								ram_waddr           = free_idx;
								ram_wdata           = {now_q + DL_W'(delay_ticks), delay_ticks,
									is_periodic, next_id_q};
								valid_n[free_idx]   = 1'b1;
								next_id_n           = next_id_q + ID_WIDTH'(1);
							end
						end
						REQ_TICK: begin
							now_n         = now_q + DL_W'(1);
							idx_n         = '0;
							fire_cnt_n    = '0;
							pend_n        = 1'b0;
							scan_ctrl.clr = 1'b1;
							state_n       = ST_SCAN;
						end
						REQ_CLEAR: begin
							valid_n = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				idx_n = idx_q + IdxW'(1);
				if (idx_q == LastIdx) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_n = ST_FIRE;
			end
			ST_FIRE: begin
				// the held beat is final only if this round found nothing
				if (pend_q) begin
					out_stb_n  = 1'b1;
					out_last_n = !best_found;
				end
				if (best_found) begin
					pend_n     = 1'b1;
					pend_id_n  = best_id;
					fire_cnt_n = fire_cnt_inc;
					if (best_periodic) begin
						ram_we    = 1'b1;
						ram_waddr = best_idx;
						ram_wdata = {now_q + rearm_step, best_per, best_periodic, best_id};
					end else begin
						valid_n[best_idx] = 1'b0;
					end
					if (fire_cnt_inc == CNT_W'(MAX_RESULTS)) begin
						state_n = ST_FLUSH;
					end else begin
						idx_n         = '0;
						scan_ctrl.clr = 1'b1;
						state_n       = ST_SCAN;
					end
				end else begin
					pend_n  = 1'b0;
					state_n = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				out_stb_n  = 1'b1;
				out_last_n = 1'b1;
				pend_n     = 1'b0;
				state_n    = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		out_id_n = id_ext[OUT_ID_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			fire_cnt_q <= '0;
			pend_q     <= 1'b0;
			now_q      <= '0;
			next_id_q  <= '0;
			valid_q    <= '0;
			out_stb_q  <= 1'b0;
		end else begin
			state_q    <= state_n;
			idx_q      <= idx_n;
			rd_vld_s1  <= ram_re;
			fire_cnt_q <= fire_cnt_n;
			pend_q     <= pend_n;
			now_q      <= now_n;
			next_id_q  <= next_id_n;
			valid_q    <= valid_n;
			out_stb_q  <= out_stb_n;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= idx_q;
		pend_id_q  <= pend_id_n;
		out_kind_q <= out_kind_n;
		out_id_q   <= out_id_n;
		out_last_q <= out_last_n;
	end

	assign strobe     = out_stb_q;
	assign event_kind = out_kind_q;
	assign alarm_id   = out_id_q;
	assign last       = out_last_q;

	`ADS_ASSERT(a_fire_from_tick, (strobe && event_kind == EV_FIRED) |-> $past(busy), "alarm fired outside a tick")
	`ADS_ASSERT(a_add_while_idle, (strobe && event_kind == EV_ADDED) |-> !busy, "add beat during a tick")
	`ADS_ASSERT(a_reject_when_full, (strobe && event_kind == EV_REJECT) |-> (&valid_q), "add rejected with a free slot")
	`ADS_NEVER(a_fire_bound, fire_cnt_q > CNT_W'(MAX_RESULTS), "too many alarms fired in one tick")

endmodule

FILE: dv/alarm_deadline_scheduler_check.sv
`timescale 1ns / 100ps

module alarm_deadline_scheduler_check import ads_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int ID_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          req_type,
	input  logic [15:0]         delay_ticks,
	input  logic                is_periodic,
	input  logic                strobe,
	input  logic [1:0]          event_kind,
	input  logic [OUT_ID_W-1:0] alarm_id,
	input  logic                last,
	output int                  failures,
	output int                  outstanding
);

	typedef struct packed {
		logic [1:0]          kind;
		logic [OUT_ID_W-1:0] id;
		logic                last;
	} alarm_event_t;

	// Shadow copy of the alarm table
	logic [DL_W-1:0]     now;
	logic [ID_WIDTH-1:0] id_counter;
	logic                armed    [CAPACITY];
	logic [DL_W-1:0]     due_at   [CAPACITY];
	logic [PER_W-1:0]    period   [CAPACITY];
	logic                repeats  [CAPACITY];
	logic [ID_WIDTH-1:0] owner_id [CAPACITY];

	alarm_event_t pending_events[$];
	alarm_event_t want;
	int           bad;

	task automatic step_schedule(input logic [1:0] req, input logic [15:0] dly,
			input logic per);
		alarm_event_t burst[$];
		alarm_event_t ev;
		int slot;
		int best;
		int i;
		logic [DL_W-1:0] age;
		logic [DL_W-1:0] best_age;
		slot = -1;
		case (req)
		REQ_ADD: begin
			for (i = 0; i < CAPACITY; i++) begin
				if (!armed[i] && slot < 0)
					slot = i;
			end
			if (slot < 0) begin
				burst.push_back('{EV_REJECT, '0, 1'b0});
			end else begin
				armed[slot]    = 1'b1;
				due_at[slot]   = now + DL_W'(dly);
				period[slot]   = dly;
				repeats[slot]  = per;
				owner_id[slot] = id_counter;
				burst.push_back('{EV_ADDED, OUT_ID_W'(id_counter), 1'b0});
				id_counter = id_counter + 1'b1;
			end
		end
		REQ_TICK: begin
			now = now + 1'b1;
			while (burst.size() < MAX_RESULTS) begin
				best = -1;
				best_age = '0;
				for (i = 0; i < CAPACITY; i++) begin
					age = now - due_at[i];
					// due while the age lies in the lower half of the time circle
					if (armed[i] && !age[DL_W-1] && (best < 0 || age > best_age ||
							(age == best_age && owner_id[i] < owner_id[best]))) begin
						best = i;
						best_age = age;
					end
				end
				if (best < 0)
					break;
				burst.push_back('{EV_FIRED, OUT_ID_W'(owner_id[best]), 1'b0});
				if (repeats[best])
					due_at[best] = now + ((period[best] == '0) ? DL_W'(1) : DL_W'(period[best]));
				else
					armed[best] = 1'b0;
			end
		end
		REQ_CLEAR: begin
			for (i = 0; i < CAPACITY; i++)
				armed[i] = 1'b0;
		end
		default: ;
		endcase
		for (i = 0; i < burst.size(); i++) begin
			ev = burst[i];
			ev.last = (i == burst.size() - 1);
			pending_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now = '0;
			id_counter = '0;
			for (int i = 0; i < CAPACITY; i++)
				armed[i] = 1'b0;
			pending_events.delete();
			bad = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (start && !busy)
				step_schedule(req_type, delay_ticks, is_periodic);
			if (strobe) begin
				if (pending_events.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: unexpected beat kind %0d id %0d last %0b",
							$realtime, event_kind, alarm_id, last);
				end else begin
					want = pending_events.pop_front();
					if (want.kind !== event_kind || want.id !== alarm_id ||
							want.last !== last) begin
						bad++;
						if (bad <= 10)
							$display("%0t: beat mismatch: kind %0d/%0d id %0d/%0d last %0b/%0b (want/got)",
								$realtime, want.kind, event_kind, want.id, alarm_id,
								want.last, last);
					end
				end
			end
			failures <= bad;
			outstanding <= pending_events.size();
		end
	end

endmodule

FILE: dv/alarm_deadline_scheduler_test.sv
`timescale 1ns / 100ps

module alarm_deadline_scheduler_test;
	import ads_pkg::*;

	localparam int         CAPACITY   = 16;
	localparam int         ID_WIDTH   = 16;
	localparam int         ITEMS      = 360;
	localparam int         CALM_TAIL  = 60;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                start       = 1'b0;
	logic [1:0]          req_type    = REQ_ADD;
	logic [15:0]         delay_ticks = '0;
	logic                is_periodic = 1'b0;
	logic                busy;
	logic                strobe;
	logic [1:0]          event_kind;
	logic [OUT_ID_W-1:0] alarm_id;
	logic                last;
	int                  failures;
	int                  outstanding;

	alarm_deadline_scheduler #(
		.CAPACITY(CAPACITY),
		.ID_WIDTH(ID_WIDTH)
	) i_dut (.*);

	alarm_deadline_scheduler_check #(
		.CAPACITY(CAPACITY),
		.ID_WIDTH(ID_WIDTH)
	) i_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold start until the beat is taken; returns at the accepting edge
	task automatic issue(input logic [1:0] req, input logic [15:0] dly, input logic per);
		start <= 1'b1;
		req_type <= req;
		delay_ticks <= dly;
		is_periodic <= per;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		int counted;
		int roll;
		logic [1:0] req;
		logic [15:0] dly;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero delay one-shot, then zero period periodic rearmed each tick
		issue(REQ_ADD, 16'd0, 1'b0);
		issue(REQ_TICK, 16'd0, 1'b0);
		issue(REQ_ADD, 16'd0, 1'b1);
		pause(3);
		issue(REQ_TICK, 16'd0, 1'b0);
		issue(REQ_CLEAR, 16'hFFFF, 1'b1);
		// fill the table, overflow it, then fire all slots on one tick
		for (int i = 0; i < CAPACITY; i++)
			issue(REQ_ADD, 16'd0, i[0]);
		issue(REQ_ADD, 16'hFFFF, 1'b1);
		issue(REQ_TICK, 16'hFFFF, 1'b1);
		issue(REQ_UNUSED, 16'hFFFF, 1'b1);
		pause(7);
		issue(REQ_TICK, 16'd0, 1'b0);
		issue(REQ_CLEAR, 16'd0, 1'b0);

		counted = 0;
		while (counted < ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 44)
				req = REQ_ADD;
			else if (roll < 92)
				req = REQ_TICK;
			else if (roll < 96)
				req = REQ_CLEAR;
			else
				req = REQ_UNUSED;
			roll = $urandom_range(99);
			// keep most delays short so alarms actually fire
			if (roll < 70)
				dly = 16'($urandom_range(12));
			else if (roll < 85)
				dly = 16'($urandom_range(255));
			else
				dly = 16'($urandom_range(16'hFFFF));
			issue(req, dly, $urandom_range(99) < 35);
			if (req != REQ_UNUSED)
				counted++;
			if (counted < ITEMS - CALM_TAIL && $urandom_range(99) < 30)
				pause($urandom_range(14, 1));
		end

		start <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		// allow a full tick with every slot firing
		repeat ((MAX_RESULTS + 1) * (CAPACITY + 3) + 20) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("alarm_deadline_scheduler_test OK");
		else
			$display("alarm_deadline_scheduler_test NOT OK");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("alarm_deadline_scheduler_test NOT OK");
		$finish;
	end

endmodule
